// File: hdl/fpip_pkg.sv
// Shared types and constants for the floating-point integer power block.
package fpip_pkg;

  localparam int unsigned EXP_BITS_DEF = 32;

  localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] DEF_NAN_BITS = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

  typedef enum logic [0:0] {
    FOP_MUL = 1'b0,
    FOP_RCP = 1'b1
  } fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

endpackage

// File: hdl/fpip_fpu.sv
// Shared multi-cycle binary64 unit: multiply and reciprocal, round to nearest even.
module fpip_fpu (
  input  logic               clk,
  input  logic               rst_n,
  input  fpip_pkg::fpu_req_t req,
  output fpip_pkg::fpu_rsp_t rsp
);

  typedef enum logic [6:0] {
    U_IDLE  = 7'b0000001,
    U_MUL   = 7'b0000010,
    U_DPRE  = 7'b0000100,
    U_DIV   = 7'b0001000,
    U_LNORM = 7'b0010000,
    U_RNORM = 7'b0100000,
    U_ROUND = 7'b1000000
  } ust_t;

  ust_t                st_r, st_nxt;
  logic [52:0]         ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [13:0]  eb_r, eb_nxt, x_r, x_nxt;
  logic                sgn_r, sgn_nxt;
  logic [105:0]        m_r, m_nxt;
  logic [53:0]         rem_r, rem_nxt;
  logic [55:0]         q_r, q_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [63:0]         res_r, res_nxt;
  logic                done_r, done_nxt;

  logic [10:0] ea_f, eb_f;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [26:0] pa, pb;
  logic [53:0] pp;
  logic [105:0] pp_sh;
  logic        dbit;
  logic [53:0] rem_sub;
  logic [52:0] mant;
  logic        grd, stk, inc;
  logic [53:0] sum;
  logic signed [13:0] xo;
  logic [10:0] efld;
  logic [51:0] ffld;

  assign ea_f   = req.a[62:52];
  assign eb_f   = req.b[62:52];
  assign a_nan  = (ea_f == 11'h7FF) && (req.a[51:0] != '0);
  assign b_nan  = (eb_f == 11'h7FF) && (req.b[51:0] != '0);
  assign a_inf  = (ea_f == 11'h7FF) && (req.a[51:0] == '0);
  assign b_inf  = (eb_f == 11'h7FF) && (req.b[51:0] == '0);
  assign a_zero = (req.a[62:0] == '0);
  assign b_zero = (req.b[62:0] == '0);

  assign pa    = cnt_r[1] ? {1'b0, ma_r[52:27]} : ma_r[26:0];
  assign pb    = cnt_r[0] ? {1'b0, mb_r[52:27]} : mb_r[26:0];
  assign pp    = pa * pb;
  assign pp_sh = {52'b0, pp} << (7'(cnt_r[1]) * 7'd27 + 7'(cnt_r[0]) * 7'd27);

  assign dbit    = (rem_r >= {1'b0, mb_r});
  assign rem_sub = dbit ? (rem_r - {1'b0, mb_r}) : rem_r;

  assign mant = m_r[105:53];
  assign grd  = m_r[52];
  assign stk  = |m_r[51:0];
  assign inc  = grd & (stk | mant[0]);
  assign sum  = {1'b0, mant} + 54'(inc);

  always_comb begin
    xo   = x_r;
    ffld = sum[51:0];
    efld = '0;
    if (sum[53]) begin
      xo   = x_r + 14'sd1;
      ffld = sum[52:1];
    end
    if (sum[53] || sum[52]) begin
      efld = xo[10:0];
    end
  end

  always_comb begin
    st_nxt   = st_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    eb_nxt   = eb_r;
    x_nxt    = x_r;
    sgn_nxt  = sgn_r;
    m_nxt    = m_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    case (st_r)
      U_IDLE: begin
        if (req.start) begin
          if (req.op == fpip_pkg::FOP_MUL) begin
            sgn_nxt = req.a[63] ^ req.b[63];
            if (a_nan) begin
              res_nxt  = req.a | fpip_pkg::QUIET_BIT;
              done_nxt = 1'b1;
            end else if (b_nan) begin
              res_nxt  = req.b | fpip_pkg::QUIET_BIT;
              done_nxt = 1'b1;
            end else if (a_inf || b_inf) begin
              res_nxt  = (a_zero || b_zero) ? fpip_pkg::DEF_NAN_BITS :
                         {req.a[63] ^ req.b[63], fpip_pkg::POS_INF_BITS[62:0]};
              done_nxt = 1'b1;
            end else if (a_zero || b_zero) begin
              res_nxt  = {req.a[63] ^ req.b[63], 63'b0};
              done_nxt = 1'b1;
            end else begin
              ma_nxt  = {ea_f != '0, req.a[51:0]};
              mb_nxt  = {eb_f != '0, req.b[51:0]};
              x_nxt   = 14'($signed({3'b0, (ea_f == '0) ? 11'd1 : ea_f})) +
                        14'($signed({3'b0, (eb_f == '0) ? 11'd1 : eb_f})) - 14'sd1022;
              m_nxt   = '0;
              cnt_nxt = '0;
              st_nxt  = U_MUL;
            end
          end else begin
            sgn_nxt = req.b[63];
            if (b_nan) begin
              res_nxt  = req.b | fpip_pkg::QUIET_BIT;
              done_nxt = 1'b1;
            end else if (b_inf) begin
              res_nxt  = {req.b[63], 63'b0};
              done_nxt = 1'b1;
            end else if (b_zero) begin
              res_nxt  = {req.b[63], fpip_pkg::POS_INF_BITS[62:0]};
              done_nxt = 1'b1;
            end else begin
              mb_nxt = {eb_f != '0, req.b[51:0]};
              eb_nxt = 14'($signed({3'b0, (eb_f == '0) ? 11'd1 : eb_f}));
              st_nxt = U_DPRE;
            end
          end
        end
      end
      U_MUL: begin
        m_nxt   = m_r + pp_sh;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd3) begin
          st_nxt = U_LNORM;
        end
      end
      U_DPRE: begin
        if (!mb_r[52]) begin
          mb_nxt = {mb_r[51:0], 1'b0};
          eb_nxt = eb_r - 14'sd1;
        end else begin
          x_nxt   = 14'sd2046 - eb_r;
          rem_nxt = 54'd1 << 52;
          q_nxt   = '0;
          cnt_nxt = '0;
          st_nxt  = U_DIV;
        end
      end
      U_DIV: begin
        rem_nxt = {rem_sub[52:0], 1'b0};
        q_nxt   = {q_r[54:0], dbit};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd55) begin
          m_nxt  = {q_r[54:0], dbit, 49'b0, rem_sub != '0};
          st_nxt = U_LNORM;
        end
      end
      U_LNORM: begin
        if (!m_r[105]) begin
          m_nxt = {m_r[104:0], 1'b0};
          x_nxt = x_r - 14'sd1;
        end else if (x_r < -14'sd60) begin
          m_nxt  = {105'b0, 1'b1};
          x_nxt  = 14'sd1;
          st_nxt = U_ROUND;
        end else if (x_r < 14'sd1) begin
          st_nxt = U_RNORM;
        end else begin
          st_nxt = U_ROUND;
        end
      end
      U_RNORM: begin
        if (x_r < 14'sd1) begin
          m_nxt = {1'b0, m_r[105:2], m_r[1] | m_r[0]};
          x_nxt = x_r + 14'sd1;
        end else begin
          st_nxt = U_ROUND;
        end
      end
      U_ROUND: begin
        if (xo > 14'sd2046) begin
          res_nxt = {sgn_r, fpip_pkg::POS_INF_BITS[62:0]};
        end else begin
          res_nxt = {sgn_r, efld, ffld};
        end
        done_nxt = 1'b1;
        st_nxt   = U_IDLE;
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    eb_r  <= eb_nxt;
    x_r   <= x_nxt;
    sgn_r <= sgn_nxt;
    m_r   <= m_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// File: hdl/fp_integer_power_core.sv
// Top level: square-and-multiply sequencer around the shared floating-point unit.
//
//  channel | handshake            | payload
//  in      | in_tvalid/in_tready  | in_tdata: base_bits, exponent
//  out     | out_tvalid/out_tready| out_tdata: power_bits
//
// One transaction at a time; in_tready is high only when the block is idle.
// Sequence: a leading-zero scan of the exponent, then squares and multiplies by the
// base, and a final reciprocal for negative exponents, all through the one shared
// unit; subnormal operands or results add a step per normalization shift.
// Zero bases, a base of one and zero exponents are offered the cycle after acceptance.
// The result is held in out_tdata until taken. Synchronous active-low reset.
module fp_integer_power_core #(
  parameter int unsigned EXP_BITS = fpip_pkg::EXP_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [63:0] base_bits, [64+EXP_BITS-1:64] exponent
  input  logic [((64 + EXP_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [63:0] power_bits
  output logic [63:0]                            out_tdata
);

  localparam int unsigned CW = $clog2(EXP_BITS);

  typedef enum logic [7:0] {
    C_IDLE = 8'b00000001,
    C_FIND = 8'b00000010,
    C_STEP = 8'b00000100,
    C_SQW  = 8'b00001000,
    C_MBW  = 8'b00010000,
    C_DIVW = 8'b00100000,
    C_OUT  = 8'b01000000,
    C_ISS  = 8'b10000000
  } cst_t;

  cst_t                st_r, st_nxt;
  logic [63:0]         x_r, x_nxt, acc_r, acc_nxt, res_r, res_nxt;
  logic [EXP_BITS-1:0] sh_r, sh_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  fpip_pkg::fpu_req_t  req_r, req_nxt;
  fpip_pkg::fpu_rsp_t  rsp;

  logic [63:0]         in_base;
  logic [EXP_BITS-1:0] in_exp, in_mag;

  assign in_base = in_tdata[63:0];
  assign in_exp  = in_tdata[64 +: EXP_BITS];
  assign in_mag  = in_exp[EXP_BITS-1] ? (~in_exp + 1'b1) : in_exp;

  fpip_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_comb begin
    st_nxt    = st_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    req_nxt   = req_r;
    req_nxt.start = 1'b0;
    case (st_r)
      C_IDLE: begin
        if (in_tvalid) begin
          x_nxt   = in_base;
          acc_nxt = in_base;
          neg_nxt = in_exp[EXP_BITS-1];
          sh_nxt  = in_mag;
          cnt_nxt = CW'(EXP_BITS - 1);
          if (in_base[62:0] == '0) begin
            res_nxt = '0;
            st_nxt  = C_OUT;
          end else if (in_base == fpip_pkg::ONE_BITS || in_mag == '0) begin
            res_nxt = fpip_pkg::ONE_BITS;
            st_nxt  = C_OUT;
          end else begin
            st_nxt = C_FIND;
          end
        end
      end
      C_FIND: begin
        if (sh_r[EXP_BITS-1]) begin
          st_nxt = C_STEP;
        end else begin
          sh_nxt  = {sh_r[EXP_BITS-2:0], 1'b0};
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      C_STEP: begin
        if (cnt_r == '0) begin
          if (!neg_r) begin
            res_nxt = acc_r;
            st_nxt  = C_OUT;
          end else if (acc_r[62:0] == '0) begin
            res_nxt = {acc_r[63], fpip_pkg::POS_INF_BITS[62:0]};
            st_nxt  = C_OUT;
          end else begin
            req_nxt = '{start: 1'b1, op: fpip_pkg::FOP_RCP, a: fpip_pkg::ONE_BITS, b: acc_r};
            st_nxt  = C_DIVW;
          end
        end else begin
          sh_nxt  = {sh_r[EXP_BITS-2:0], 1'b0};
          cnt_nxt = cnt_r - 1'b1;
          req_nxt = '{start: 1'b1, op: fpip_pkg::FOP_MUL, a: acc_r, b: acc_r};
          st_nxt  = C_SQW;
        end
      end
      C_SQW: begin
        if (rsp.done) begin
          acc_nxt = rsp.res;
          st_nxt  = sh_r[EXP_BITS-1] ? C_ISS : C_STEP;
        end
      end
      C_ISS: begin
        req_nxt = '{start: 1'b1, op: fpip_pkg::FOP_MUL, a: acc_r, b: x_r};
        st_nxt  = C_MBW;
      end
      C_MBW: begin
        if (rsp.done) begin
          acc_nxt = rsp.res;
          st_nxt  = C_STEP;
        end
      end
      C_DIVW: begin
        if (rsp.done) begin
          res_nxt = rsp.res;
          st_nxt  = C_OUT;
        end
      end
      C_OUT: begin
        if (out_tready) begin
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= C_IDLE;
      req_r.start <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      req_r.start <= req_nxt.start;
    end
    req_r.op <= req_nxt.op;
    req_r.a  <= req_nxt.a;
    req_r.b  <= req_nxt.b;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign in_tready  = (st_r == C_IDLE);
  assign out_tvalid = (st_r == C_OUT);
  assign out_tdata  = res_r;

endmodule

// File: sim/fp_integer_power_core_tb.sv
// Testbench for fp_integer_power_core: random and directed base/exponent streams, scoreboard check.
module fp_integer_power_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EXPW  = fpip_pkg::EXP_BITS_DEF;
  localparam int unsigned DATAW = ((64 + EXPW + 7) / 8) * 8;
  localparam int          NUM_RANDOM = 1200;

  class power_scoreboard;
    logic [63:0] expected_powers[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function logic [63:0] pow_bits(logic [63:0] base, logic [EXPW-1:0] raw);
      logic        neg;
      logic [EXPW-1:0] mag;
      logic [63:0] ab;
      real         x;
      real         acc;
      int          top;
      neg = raw[EXPW-1];
      mag = neg ? (~raw + 1'b1) : raw;
      if (base[62:0] == 63'd0) return 64'd0;
      if (base == fpip_pkg::ONE_BITS || mag == '0) return fpip_pkg::ONE_BITS;
      // NaN base: passes unchanged for a power of one, else quieted by the first operation
      if (base[62:52] == 11'h7FF && base[51:0] != 52'd0) begin
        return (mag == EXPW'(1) && !neg) ? base : (base | fpip_pkg::QUIET_BIT);
      end
      top = EXPW - 1;
      while (top > 0 && !mag[top]) top--;
      x = $bitstoreal(base);
      acc = x;
      for (int i = top - 1; i >= 0; i--) begin
        acc = acc * acc;
        if (mag[i]) acc = acc * x;
      end
      ab = $realtobits(acc);
      if (neg) begin
        if (ab[62:0] == 63'd0) return ab[63] ? fpip_pkg::NEG_INF_BITS : fpip_pkg::POS_INF_BITS;
        acc = 1.0 / acc;
        ab = $realtobits(acc);
      end
      return ab;
    endfunction

    function void note_input(logic [63:0] base, logic [EXPW-1:0] raw);
      expected_powers.push_back(pow_bits(base, raw));
    endfunction

    function void check_result(logic [63:0] actual);
      logic [63:0] want;
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, actual);
        errors++;
        return;
      end
      want = expected_powers.pop_front();
      if (want !== actual) begin
        $display("%0t: power_bits mismatch, expected %h, actual %h", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [DATAW-1:0] in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [63:0]      out_tdata;

  power_scoreboard sb = new();
  bit              no_idle = 1'b0;
  bit              hold_off = 1'b0;

  always #5 clk = ~clk;

  fp_integer_power_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready = 1'b0;
        for (n = 0; n < 3000; n++) @(negedge clk);
        hold_off = 1'b0;
      end
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  task automatic send_power(logic [63:0] base, logic [EXPW-1:0] raw);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tdata  = '0;
    in_tdata[63:0] = base;
    in_tdata[64 +: EXPW] = raw;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(base, raw);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_base();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    ;
      2:       b[62:52] = 11'h7FF;
      3:       b[62:52] = 11'h000;
      4:       b = fpip_pkg::ONE_BITS;
      5:       b[62:0] = 63'd0;
      default: b[62:52] = 11'(11'h3FE + $urandom_range(0, 1));
    endcase
    return b;
  endfunction

  function automatic logic [EXPW-1:0] rand_exp();
    int e;
    case ($urandom_range(0, 9))
      0:       return EXPW'($urandom);
      1:       return {1'b1, {(EXPW-1){1'b0}}};
      2:       return '0;
      3:       return {1'b0, {(EXPW-1){1'b1}}};
      default: begin
        e = $urandom_range(0, 4000) - 2000;
        if ($urandom_range(0, 1)) e = $urandom_range(0, 80) - 40;
        return EXPW'(e);
      end
    endcase
  endfunction

  initial begin
    int wait_cycles;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_power(64'h0000_0000_0000_0000, -5);
    send_power(64'h8000_0000_0000_0000, 3);
    send_power(fpip_pkg::ONE_BITS, 32'h8000_0000);
    send_power(64'h7FF8_0000_0000_0001, 0);
    send_power(64'h4000_0000_0000_0000, 0);
    send_power(64'h4000_0000_0000_0000, 10);
    send_power(64'h4000_0000_0000_0000, -10);
    send_power(64'h3FF0_0000_0000_0001, 32'h8000_0000);
    send_power(64'h3FF0_0000_0000_0001, 32'h7FFF_FFFF);
    send_power(64'h3FE0_0000_0000_0000, -2000);
    send_power(64'hBFE0_0000_0000_0000, -2001);
    send_power(64'h3FE0_0000_0000_0000, 2000);
    send_power(fpip_pkg::POS_INF_BITS, 3);
    send_power(fpip_pkg::NEG_INF_BITS, -3);
    send_power(fpip_pkg::NEG_INF_BITS, 2);
    send_power(64'h7FF0_0000_0000_0001, 3);
    send_power(64'h7FF0_0000_0000_0001, 1);
    send_power(64'hFFFF_FFFF_FFFF_FFFF, -7);
    send_power(64'h7FEF_FFFF_FFFF_FFFF, 2);
    send_power(64'h0000_0000_0000_0001, 1);
    send_power(64'h0000_0000_0000_0001, -1);
    send_power(64'h000F_FFFF_FFFF_FFFF, -3);
    send_power(64'hC008_0000_0000_0000, 5);

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == 300) hold_off = 1'b1;
      if (k == NUM_RANDOM - 150) no_idle = 1'b1;
      send_power(rand_base(), rand_exp());
    end
    in_tvalid = 1'b0;

    wait_cycles = 0;
    while (sb.expected_powers.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.expected_powers.size() == 0) begin
      $display("fp_integer_power_core test passed");
    end else begin
      $display("fp_integer_power_core test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("fp_integer_power_core test failed");
    $finish;
  end

endmodule
